>>> hw/rtl/prle_pkg.sv
// Shared types, constants and the arctangent table for the penalty rigid link element.
package prle_pkg;

  localparam logic [7:0] REG_STIFFNESS = 8'd0;
  localparam logic [7:0] REG_OFFSET_X  = 8'd1;
  localparam logic [7:0] REG_OFFSET_Y  = 8'd2;

  localparam int ANGLE_W = 35;
  localparam int CORD_W  = 33;

  localparam logic signed [ANGLE_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ANGLE_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [CORD_W-1:0]  GAIN_Q30    = 33'sd652032874;

  typedef struct packed {
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } prle_mid_t;

  typedef struct packed {
    logic [31:0] violation_x;
    logic [31:0] violation_y;
    logic [47:0] force_x0;
    logic [47:0] force_y0;
    logic [47:0] moment_0;
    logic [47:0] force_x1;
    logic [47:0] force_y1;
    logic [47:0] stiff_x0_angle;
    logic [47:0] stiff_y0_angle;
    logic [47:0] stiff_angle_angle;
    logic [62:0] energy;
  } prle_res_t;

  function automatic logic [29:0] prle_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      5'd24: v = 30'd63;
      5'd25: v = 30'd31;
      5'd26: v = 30'd15;
      5'd27: v = 30'd7;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd0;
      5'd31: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/prle_fifo.sv
// Small register FIFO used between the pipeline sections and at the result side.
module prle_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + AW'(1);
      if (do_pop) rp <= rp + AW'(1);
      if (do_push && !do_pop) cnt <= cnt + CW'(1);
      else if (do_pop && !do_push) cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= wdata;
  end

endmodule

>>> hw/rtl/prle_front.sv
// Front section: angle reduction, CORDIC pipeline, offset rotation and violation forming.
module prle_front import prle_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic signed [31:0] node0_x,
  input  logic signed [31:0] node0_y,
  input  logic signed [31:0] node0_angle,
  input  logic signed [31:0] node1_x,
  input  logic signed [31:0] node1_y,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  input  logic               down_full,
  output logic               ready,
  output logic               valid,
  output prle_mid_t          item
);
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
  } pos_t;

  logic en;

  logic                      v_in, v_w;
  pos_t                      p_in, p_w;
  logic signed [ANGLE_W-1:0] th_in, th_w;

  logic                      v_c [0:CORDIC_STEPS];
  pos_t                      p_c [0:CORDIC_STEPS];
  logic                      f_c [0:CORDIC_STEPS];
  logic signed [ANGLE_W-1:0] z_c [0:CORDIC_STEPS];
  logic signed [CORD_W-1:0]  x_c [0:CORDIC_STEPS];
  logic signed [CORD_W-1:0]  y_c [0:CORDIC_STEPS];

  logic               v_f, v_m, v_r, v_o;
  pos_t               p_f, p_m, p_r;
  logic signed [33:0] cs, sn;
  logic signed [65:0] pxc, pys, pxs, pyc;
  logic signed [36:0] rx, ry;
  logic signed [66:0] tx, ty;
  logic signed [38:0] s1, s2;
  logic signed [37:0] na;

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -39'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] satsym(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -38'sd2147483647) r = -32'sd2147483647;
    else r = v[31:0];
    return r;
  endfunction

  assign en    = !v_o || !down_full;
  assign ready = en;
  assign valid = v_o;

  assign tx = 67'(pxc) - 67'(pys) + 67'sd536870912;
  assign ty = 67'(pxs) + 67'(pyc) + 67'sd536870912;
  assign s1 = 39'(rx) + 39'(p_r.x0) - 39'(p_r.x1);
  assign s2 = 39'(ry) + 39'(p_r.y0) - 39'(p_r.y1);
  assign na = -38'(ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in   <= 1'b0;
      v_w    <= 1'b0;
      v_c[0] <= 1'b0;
      v_f    <= 1'b0;
      v_m    <= 1'b0;
      v_r    <= 1'b0;
      v_o    <= 1'b0;
    end else if (en) begin
      v_in   <= load;
      v_w    <= v_in;
      v_c[0] <= v_w;
      v_f    <= v_c[CORDIC_STEPS];
      v_m    <= v_f;
      v_r    <= v_m;
      v_o    <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_in  <= '{x0: node0_x, y0: node0_y, x1: node1_x, y1: node1_y};
      th_in <= {node0_angle[31], node0_angle, 2'b00};

      p_w <= p_in;
      if (th_in > PI_Q30) th_w <= th_in - TWO_PI_Q30;
      else if (th_in < -PI_Q30) th_w <= th_in + TWO_PI_Q30;
      else th_w <= th_in;

      p_c[0] <= p_w;
      x_c[0] <= GAIN_Q30;
      y_c[0] <= '0;
      if (th_w > HALF_PI_Q30) begin
        z_c[0] <= th_w - PI_Q30;
        f_c[0] <= 1'b1;
      end else if (th_w < -HALF_PI_Q30) begin
        z_c[0] <= th_w + PI_Q30;
        f_c[0] <= 1'b1;
      end else begin
        z_c[0] <= th_w;
        f_c[0] <= 1'b0;
      end

      p_f <= p_c[CORDIC_STEPS];
      cs  <= f_c[CORDIC_STEPS] ? -34'(x_c[CORDIC_STEPS]) : 34'(x_c[CORDIC_STEPS]);
      sn  <= f_c[CORDIC_STEPS] ? -34'(y_c[CORDIC_STEPS]) : 34'(y_c[CORDIC_STEPS]);

      p_m <= p_f;
      pxc <= dx * cs;
      pys <= dy * sn;
      pxs <= dx * sn;
      pyc <= dy * cs;

      p_r <= p_m;
      rx  <= 37'(tx >>> 30);
      ry  <= 37'(ty >>> 30);

      item.c1 <= sat32(s1);
      item.c2 <= sat32(s2);
      item.a  <= satsym(na);
      item.b  <= satsym(38'(rx));
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ANGLE_W-1:0] ATAN = $signed(ANGLE_W'(prle_atan(5'(i))));

    always_ff @(posedge clk) begin
      if (rst) v_c[i+1] <= 1'b0;
      else if (en) v_c[i+1] <= v_c[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_c[i+1] <= p_c[i];
        f_c[i+1] <= f_c[i];
        if (!z_c[i][ANGLE_W-1]) begin
          x_c[i+1] <= x_c[i] - (y_c[i] >>> i);
          y_c[i+1] <= y_c[i] + (x_c[i] >>> i);
          z_c[i+1] <= z_c[i] - ATAN;
        end else begin
          x_c[i+1] <= x_c[i] + (y_c[i] >>> i);
          y_c[i+1] <= y_c[i] - (x_c[i] >>> i);
          z_c[i+1] <= z_c[i] + ATAN;
        end
      end
    end
  end

endmodule

>>> hw/rtl/prle_back.sv
// Back section: cross products, stiffness scaling, rounding and saturation of all results but the violation.
module prle_back import prle_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  prle_mid_t   in_item,
  input  logic [31:0] k,
  input  logic        down_full,
  output logic        ready,
  output logic        valid,
  output prle_res_t   res
);
  localparam int LANES = 7;
  localparam int SHIFT [0:LANES-1] = '{FRAC_BITS, FRAC_BITS, 2 * FRAC_BITS, FRAC_BITS,
                                       FRAC_BITS, 2 * FRAC_BITS - 2, 2 * FRAC_BITS + 1};
  localparam logic [96:0] LIM_POS = 97'h7FFF_FFFF_FFFF;
  localparam logic [96:0] LIM_NEG = 97'h8000_0000_0000;
  localparam logic [96:0] LIM_E   = 97'h7FFF_FFFF_FFFF_FFFF;

  logic en;
  logic v0, v1, v2, v3, v4, v5, v6;

  prle_mid_t m0, m1, m2;
  logic signed [63:0] p_c1a, p_c2b, p_aa, p_bb, p_c1b, p_c2a;
  logic [63:0]        p_c1c1, p_c2c2;
  logic signed [63:0] inner, diag;
  logic [63:0]        sq;

  logic signed [64:0] val [0:LANES-1];
  logic [63:0]        mag [0:LANES-1];
  logic               sg3 [0:LANES-1];
  logic               sg4 [0:LANES-1];
  logic               sg5 [0:LANES-1];
  logic [63:0]        lo  [0:LANES-1];
  logic [63:0]        hi  [0:LANES-1];
  logic [95:0]        prod [0:LANES-1];
  logic [96:0]        q   [0:LANES-1];
  logic [63:0]        viol3, viol4, viol5;

  function automatic logic [47:0] k48(input logic [96:0] qv, input logic neg);
    logic [96:0] lim;
    logic [47:0] mq;
    lim = neg ? LIM_NEG : LIM_POS;
    mq  = (qv > lim) ? lim[47:0] : qv[47:0];
    return neg ? 48'(-mq) : mq;
  endfunction

  assign en    = !v6 || !down_full;
  assign ready = en;
  assign valid = v6;

  always_comb begin
    val[0] = 65'(m2.c1);
    val[1] = 65'(m2.c2);
    val[2] = 65'(inner);
    val[3] = 65'(m2.a);
    val[4] = 65'(m2.b);
    val[5] = 65'(diag);
    val[6] = $signed({1'b0, sq});
    for (int l = 0; l < LANES; l++) begin
      q[l] = (97'(prod[l]) + (97'(1) << (SHIFT[l] - 1))) >> SHIFT[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= in_item;

      m1     <= m0;
      p_c1a  <= m0.c1 * m0.a;
      p_c2b  <= m0.c2 * m0.b;
      p_aa   <= m0.a * m0.a;
      p_bb   <= m0.b * m0.b;
      p_c1b  <= m0.c1 * m0.b;
      p_c2a  <= m0.c2 * m0.a;
      p_c1c1 <= 64'(m0.c1 * m0.c1);
      p_c2c2 <= 64'(m0.c2 * m0.c2);

      m2    <= m1;
      inner <= p_c1a + p_c2b;
      diag  <= (p_aa >>> 2) + (p_bb >>> 2) - (p_c1b >>> 2) + (p_c2a >>> 2);
      sq    <= p_c1c1 + p_c2c2;

      viol3 <= {m2.c1, m2.c2};
      viol4 <= viol3;
      viol5 <= viol4;
      for (int l = 0; l < LANES; l++) begin
        sg3[l]  <= val[l][64];
        mag[l]  <= val[l][64] ? 64'(-val[l]) : 64'(val[l]);
        sg4[l]  <= sg3[l];
        lo[l]   <= mag[l][31:0] * k;
        hi[l]   <= mag[l][63:32] * k;
        sg5[l]  <= sg4[l];
        prod[l] <= {32'b0, lo[l]} + {hi[l], 32'b0};
      end

      res.violation_x       <= viol5[63:32];
      res.violation_y       <= viol5[31:0];
      res.force_x0          <= k48(q[0], sg5[0]);
      res.force_x1          <= k48(q[0], !sg5[0]);
      res.force_y0          <= k48(q[1], sg5[1]);
      res.force_y1          <= k48(q[1], !sg5[1]);
      res.moment_0          <= k48(q[2], sg5[2]);
      res.stiff_x0_angle    <= k48(q[3], sg5[3]);
      res.stiff_y0_angle    <= k48(q[4], sg5[4]);
      res.stiff_angle_angle <= k48(q[5], sg5[5]);
      res.energy            <= (q[6] > LIM_E) ? LIM_E[62:0] : q[6][62:0];
    end
  end

endmodule

>>> hw/rtl/penalty_rigid_link_element_core.sv
// Top level of the 2D penalty rigid link element evaluator.
//
//   channel   direction  handshake          beat
//   node      in         push / full        node0_x, node0_y, node0_angle, node1_x, node1_y
//   result    out        empty / pop        violation, forces, moment, stiffness, energy
//   config    in         cfg_write          cfg_index selects the register, cfg_data the value
//
// One beat is accepted per cycle while full is low; the pipeline depth is set by the
// CORDIC pipeline (one stage per step) and the multiply stages behind it.
// Reset is synchronous and clears all control state and the three registers.
// A full result queue stalls the back section, which then fills the middle queue and
// stalls the front section; full rises only then.
module penalty_rigid_link_element_core import prle_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] node0_x,
  input  logic signed [31:0] node0_y,
  input  logic signed [31:0] node0_angle,
  input  logic signed [31:0] node1_x,
  input  logic signed [31:0] node1_y,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] violation_x,
  output logic signed [31:0] violation_y,
  output logic signed [47:0] force_x0,
  output logic signed [47:0] force_y0,
  output logic signed [47:0] moment_0,
  output logic signed [47:0] force_x1,
  output logic signed [47:0] force_y1,
  output logic signed [47:0] stiff_x0_angle,
  output logic signed [47:0] stiff_y0_angle,
  output logic signed [47:0] stiff_angle_angle,
  output logic [62:0]        energy,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  logic [31:0]        stiffness;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;

  logic      f_ready, f_valid;
  prle_mid_t f_item, mq_item;
  logic      mq_full, mq_empty, mq_push, mq_pop;
  logic      b_ready, b_valid;
  prle_res_t b_res, oq_res;
  logic      oq_full, oq_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= '0;
      offset_x  <= '0;
      offset_y  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STIFFNESS: stiffness <= cfg_data;
        REG_OFFSET_X:  offset_x  <= cfg_data;
        REG_OFFSET_Y:  offset_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full    = !f_ready;
  assign mq_push = f_valid && !mq_full;
  assign mq_pop  = b_ready && !mq_empty;
  assign oq_push = b_valid && !oq_full;

  prle_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .load        (push),
    .node0_x     (node0_x),
    .node0_y     (node0_y),
    .node0_angle (node0_angle),
    .node1_x     (node1_x),
    .node1_y     (node1_y),
    .dx          (offset_x),
    .dy          (offset_y),
    .down_full   (mq_full),
    .ready       (f_ready),
    .valid       (f_valid),
    .item        (f_item)
  );

  prle_fifo #(.WIDTH($bits(prle_mid_t)), .DEPTH(4)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mq_push),
    .wdata (f_item),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_item),
    .empty (mq_empty)
  );

  prle_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!mq_empty),
    .in_item   (mq_item),
    .k         (stiffness),
    .down_full (oq_full),
    .ready     (b_ready),
    .valid     (b_valid),
    .res       (b_res)
  );

  prle_fifo #(.WIDTH($bits(prle_res_t)), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (b_res),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_res),
    .empty (empty)
  );

  assign violation_x       = oq_res.violation_x;
  assign violation_y       = oq_res.violation_y;
  assign force_x0          = oq_res.force_x0;
  assign force_y0          = oq_res.force_y0;
  assign moment_0          = oq_res.moment_0;
  assign force_x1          = oq_res.force_x1;
  assign force_y1          = oq_res.force_y1;
  assign stiff_x0_angle    = oq_res.stiff_x0_angle;
  assign stiff_y0_angle    = oq_res.stiff_y0_angle;
  assign stiff_angle_angle = oq_res.stiff_angle_angle;
  assign energy            = oq_res.energy;

`ifndef SYNTHESIS
  a_reset_clean: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("Queues not cleared by reset.");

  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    f_valid && mq_full |=> f_valid)
    else $error("Front section dropped a beat while the middle queue was full.");

  a_back_holds: assert property (@(posedge clk) disable iff (rst)
    b_valid && oq_full |=> b_valid)
    else $error("Back section dropped a beat while the result queue was full.");
`endif

endmodule
